>>> sv/sclc_pkg.sv
// ----------------------------------------------------------------------------
// sclc_pkg
// Types, constants and checker functions shared by the command line lexer.
// ----------------------------------------------------------------------------
package sclc_pkg;

    localparam int TOKEN_LIMIT_DEF = 100;
    localparam int WORD_LIMIT_DEF  = 50;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_LESS  = 8'h3C;
    localparam logic [7:0] CHAR_MORE  = 8'h3E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    typedef enum logic [2:0] {
        EV_BYTE = 3'd0,
        EV_WEND = 3'd1,
        EV_PIPE = 3'd2,
        EV_RIN  = 3'd3,
        EV_ROUT = 3'd4,
        EV_END  = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        V_PENDING = 3'd0,
        V_SUCCESS = 3'd1,
        V_EMPTY   = 3'd2,
        V_CMD     = 3'd3,
        V_FILE    = 3'd4,
        V_PIPE    = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_ARGS  = 2'd1,
        MODE_FILE  = 2'd2,
        MODE_PIPED = 2'd3
    } check_mode_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
    } req_beat_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] out_byte;
        logic [6:0] token_index;
        verdict_t   verdict;
        logic       last;
    } res_beat_t;

    typedef struct packed {
        check_mode_t mode;
        verdict_t    err;
    } checker_t;

    localparam checker_t CHECKER_RESET = '{mode: MODE_START, err: V_PENDING};

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic checker_t check_step(input checker_t cur, input event_t ev);
        checker_t nxt;
        nxt = cur;
        if (cur.err == V_PENDING)
        begin
            unique case (cur.mode)
                MODE_START, MODE_PIPED:
                begin
                    if (ev == EV_WEND) nxt.mode = MODE_ARGS;
                    else               nxt.err  = V_CMD;
                end
                MODE_FILE:
                begin
                    if (ev == EV_WEND) nxt.mode = MODE_ARGS;
                    else               nxt.err  = V_FILE;
                end
                MODE_ARGS:
                begin
                    if (ev == EV_PIPE)                        nxt.mode = MODE_PIPED;
                    else if (ev == EV_RIN || ev == EV_ROUT)   nxt.mode = MODE_FILE;
                end
            endcase
        end
        return nxt;
    endfunction

    function automatic verdict_t end_verdict(input checker_t cur);
        verdict_t v;
        if (cur.err != V_PENDING)
        begin
            v = cur.err;
        end
        else
        begin
            unique case (cur.mode)
                MODE_START: v = V_EMPTY;
                MODE_PIPED: v = V_PIPE;
                MODE_FILE:  v = V_FILE;
                MODE_ARGS:  v = V_SUCCESS;
            endcase
        end
        return v;
    endfunction

endpackage

>>> sv/shell_command_lexer_checker.sv
// ----------------------------------------------------------------------------
// shell_command_lexer_checker
// Command line lexer with a syntax checker alongside.
// ----------------------------------------------------------------------------
// A line arrives on req as one byte beat per character and closes with an
// end-of-line beat (req_type high). Each req beat gives zero, one or two
// res beats: word bytes, word ends, operator tokens and, at end of line, an
// END beat carrying the verdict. last marks the final res beat of a req beat.
// Every req beat is classified and the lexer and checker state updated in
// the cycle it is taken; its res beats are registered into a four-entry
// output queue and leave it on res in order, behind any older beats.
// req_ready stays high while at least two queue slots are free, so one req
// beat is taken every cycle as long as res is drained; beats giving two
// results fill the queue faster than the single res port empties it.
// When the receiver stalls res, the queue fills and req_ready drops until
// two slots are free again; nothing is lost or repeated.
// Reset clears the queue, empties the line state and puts the checker back
// at start of line. An end-of-line beat also clears the line state.
// ----------------------------------------------------------------------------
module shell_command_lexer_checker #(
    parameter int TOKEN_LIMIT = sclc_pkg::TOKEN_LIMIT_DEF,
    parameter int WORD_LIMIT  = sclc_pkg::WORD_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  sclc_pkg::req_beat_t req,
    output logic                res_valid,
    input  logic                res_ready,
    output sclc_pkg::res_beat_t res
);

    localparam int TW = (TOKEN_LIMIT > 2) ? $clog2(TOKEN_LIMIT) : 1;
    localparam int WW = (WORD_LIMIT > 2) ? $clog2(WORD_LIMIT) : 1;
    localparam logic [TW-1:0] TOKEN_MAX = TW'(TOKEN_LIMIT - 1);
    localparam logic [WW-1:0] WORD_MAX  = WW'(WORD_LIMIT - 1);

    logic                          in_word_reg,     in_word_next;
    logic [WW-1:0]                 word_length_reg, word_length_next;
    logic [TW-1:0]                 token_total_reg, token_total_next;
    sclc_pkg::checker_t            checker_reg,     checker_next;

    sclc_pkg::res_beat_t           queue_reg [sclc_pkg::QUEUE_DEPTH];
    logic [sclc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sclc_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;

    sclc_pkg::res_beat_t           slot0, slot1;
    logic [1:0]                    n_res;
    logic                          req_fire, res_fire;
    logic [7:0]                    c;
    logic                          is_op;
    sclc_pkg::event_t              op_ev;

    assign req_fire  = req_valid && req_ready;
    assign res_fire  = res_valid && res_ready;
    assign req_ready = count_reg <= sclc_pkg::QUEUE_CNT_W'(sclc_pkg::QUEUE_DEPTH - 2);
    assign res_valid = count_reg != '0;
    assign res       = queue_reg[rd_ptr_reg];
    assign c         = req.char_byte;
    assign is_op     = (c == sclc_pkg::CHAR_PIPE) || (c == sclc_pkg::CHAR_LESS)
                       || (c == sclc_pkg::CHAR_MORE);

    always_comb
    begin
        priority if (c == sclc_pkg::CHAR_PIPE) op_ev = sclc_pkg::EV_PIPE;
        else if (c == sclc_pkg::CHAR_LESS)     op_ev = sclc_pkg::EV_RIN;
        else                                   op_ev = sclc_pkg::EV_ROUT;
    end

    // lexer step for one beat
    always_comb
    begin
        in_word_next     = in_word_reg;
        word_length_next = word_length_reg;
        token_total_next = token_total_reg;
        checker_next     = checker_reg;
        slot0            = '0;
        slot1            = '0;
        n_res            = 2'd0;

        if (in_word_reg && (req.req_type == sclc_pkg::REQ_EOL || is_op
                            || sclc_pkg::is_space(c)))
        begin
            slot0.event_res   = sclc_pkg::EV_WEND;
            slot0.token_index = 7'(token_total_reg);
            n_res             = 2'd1;
            checker_next      = sclc_pkg::check_step(checker_next, sclc_pkg::EV_WEND);
            token_total_next  = token_total_reg + TW'(1);
            in_word_next      = 1'b0;
            word_length_next  = '0;
        end

        if (req.req_type == sclc_pkg::REQ_EOL)
        begin
            slot1.event_res   = sclc_pkg::EV_END;
            slot1.token_index = 7'(token_total_next);
            slot1.verdict     = sclc_pkg::end_verdict(checker_next);
            if (n_res == 2'd0) slot0 = slot1;
            n_res             = n_res + 2'd1;
            in_word_next      = 1'b0;
            word_length_next  = '0;
            token_total_next  = '0;
            checker_next      = sclc_pkg::CHECKER_RESET;
        end
        else if (is_op)
        begin
            if (token_total_next != TOKEN_MAX)
            begin
                slot1.event_res   = op_ev;
                slot1.token_index = 7'(token_total_next);
                if (n_res == 2'd0) slot0 = slot1;
                n_res             = n_res + 2'd1;
                checker_next      = sclc_pkg::check_step(checker_next, op_ev);
                token_total_next  = token_total_next + TW'(1);
            end
        end
        else if (!sclc_pkg::is_space(c))
        begin
            if (!in_word_reg && token_total_reg != TOKEN_MAX)
            begin
                in_word_next     = 1'b1;
                word_length_next = '0;
            end
            if (in_word_next && word_length_next != WORD_MAX)
            begin
                slot0.event_res   = sclc_pkg::EV_BYTE;
                slot0.out_byte    = c;
                slot0.token_index = 7'(token_total_reg);
                n_res             = 2'd1;
                word_length_next  = word_length_next + WW'(1);
            end
        end

        if (n_res == 2'd2) slot1.last = 1'b1;
        else               slot0.last = 1'b1;
    end

    always_comb
    begin
        count_next = count_reg;
        if (req_fire) count_next = count_next + sclc_pkg::QUEUE_CNT_W'(n_res);
        if (res_fire) count_next = count_next - sclc_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg     <= 1'b0;
            word_length_reg <= '0;
            token_total_reg <= '0;
            checker_reg     <= sclc_pkg::CHECKER_RESET;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                in_word_reg     <= in_word_next;
                word_length_reg <= word_length_next;
                token_total_reg <= token_total_next;
                checker_reg     <= checker_next;
                wr_ptr_reg      <= wr_ptr_reg + sclc_pkg::QUEUE_PTR_W'(n_res);
            end
            if (res_fire) rd_ptr_reg <= rd_ptr_reg + sclc_pkg::QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // output queue payload
    always_ff @(posedge clk)
    begin
        if (req_fire && n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= slot0;
        if (req_fire && n_res == 2'd2)
            queue_reg[wr_ptr_reg + sclc_pkg::QUEUE_PTR_W'(1)] <= slot1;
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sclc_pkg::QUEUE_CNT_W'(sclc_pkg::QUEUE_DEPTH))
        else $error("output queue overfilled");

    a_token_bound: assert property (@(posedge clk) disable iff (!rst_n)
        token_total_reg <= TOKEN_MAX)
        else $error("token count beyond limit");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == sclc_pkg::REQ_EOL)
        |=> (token_total_reg == '0 && !in_word_reg && word_length_reg == '0))
        else $error("line state not cleared after end of line");

    a_verdict_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.event_res != sclc_pkg::EV_END)
        |-> (res.verdict == sclc_pkg::V_PENDING))
        else $error("verdict on a non-end beat");

    a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_length_reg <= WORD_MAX)
        else $error("word length beyond limit");

endmodule

>>> tb/sv/tb_shell_command_lexer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_command_lexer_checker
// Self-checking testbench for the command line lexer and syntax checker.
// ----------------------------------------------------------------------------
// Command lines are fed one byte beat at a time and closed by an end-of-line
// beat. A line model inside the bench tracks word state, token count and the
// syntax check, and queues the result beats each accepted beat should give.
// Every result beat is compared field by field against the oldest queued
// beat. Directed lines cover every token and verdict; then long words, the
// token limit and random lines, well-formed and broken, run under several
// idling and stalling mixes on both sides.
// ----------------------------------------------------------------------------
module tb_shell_command_lexer_checker;

    localparam int TOKEN_CAP = sclc_pkg::TOKEN_LIMIT_DEF - 1;
    localparam int WORD_CAP  = sclc_pkg::WORD_LIMIT_DEF - 1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    sclc_pkg::req_beat_t req       = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    sclc_pkg::res_beat_t res;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_taken    = 0;
    int mismatch_count = 0;

    // line model state
    logic                  line_in_word;
    int                    line_word_len;
    int                    line_tokens;
    sclc_pkg::check_mode_t syntax_mode;
    sclc_pkg::verdict_t    syntax_error;

    sclc_pkg::res_beat_t step_out [2];
    int                  step_n;
    sclc_pkg::res_beat_t expected_events [$];
    sclc_pkg::res_beat_t want_beat;

    shell_command_lexer_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic bit is_blank(input logic [7:0] c);
        return (c == sclc_pkg::CHAR_SPACE)
               || ((c >= sclc_pkg::CHAR_TAB) && (c <= sclc_pkg::CHAR_CR));
    endfunction

    function automatic bit is_operator(input logic [7:0] c);
        return (c == sclc_pkg::CHAR_PIPE) || (c == sclc_pkg::CHAR_LESS)
               || (c == sclc_pkg::CHAR_MORE);
    endfunction

    function automatic void clear_line();
        line_in_word  = 1'b0;
        line_word_len = 0;
        line_tokens   = 0;
        syntax_mode   = sclc_pkg::MODE_START;
        syntax_error  = sclc_pkg::V_PENDING;
    endfunction

    function automatic void emit(input sclc_pkg::event_t ev, input logic [7:0] b,
                                 input sclc_pkg::verdict_t v);
        step_out[step_n].event_res   = ev;
        step_out[step_n].out_byte    = b;
        step_out[step_n].token_index = 7'(line_tokens);
        step_out[step_n].verdict     = v;
        step_out[step_n].last        = 1'b0;
        step_n++;
    endfunction

    function automatic void syntax_feed(input sclc_pkg::event_t ev);
        if (syntax_error == sclc_pkg::V_PENDING)
        begin
            case (syntax_mode)
                sclc_pkg::MODE_START, sclc_pkg::MODE_PIPED:
                begin
                    if (ev == sclc_pkg::EV_WEND) syntax_mode = sclc_pkg::MODE_ARGS;
                    else                         syntax_error = sclc_pkg::V_CMD;
                end
                sclc_pkg::MODE_FILE:
                begin
                    if (ev == sclc_pkg::EV_WEND) syntax_mode = sclc_pkg::MODE_ARGS;
                    else                         syntax_error = sclc_pkg::V_FILE;
                end
                default:
                begin
                    if (ev == sclc_pkg::EV_PIPE)
                        syntax_mode = sclc_pkg::MODE_PIPED;
                    else if ((ev == sclc_pkg::EV_RIN) || (ev == sclc_pkg::EV_ROUT))
                        syntax_mode = sclc_pkg::MODE_FILE;
                end
            endcase
        end
    endfunction

    function automatic void close_word();
        emit(sclc_pkg::EV_WEND, 8'h00, sclc_pkg::V_PENDING);
        syntax_feed(sclc_pkg::EV_WEND);
        line_tokens++;
        line_in_word  = 1'b0;
        line_word_len = 0;
    endfunction

    function automatic void lex_predict(input logic kind, input logic [7:0] c);
        sclc_pkg::event_t   op;
        sclc_pkg::verdict_t v;
        step_n = 0;
        if (kind == sclc_pkg::REQ_EOL)
        begin
            if (line_in_word)
                close_word();
            if (syntax_error != sclc_pkg::V_PENDING)
                v = syntax_error;
            else
            begin
                case (syntax_mode)
                    sclc_pkg::MODE_START: v = sclc_pkg::V_EMPTY;
                    sclc_pkg::MODE_PIPED: v = sclc_pkg::V_PIPE;
                    sclc_pkg::MODE_FILE:  v = sclc_pkg::V_FILE;
                    default:              v = sclc_pkg::V_SUCCESS;
                endcase
            end
            emit(sclc_pkg::EV_END, 8'h00, v);
            clear_line();
        end
        else if (is_blank(c))
        begin
            if (line_in_word)
                close_word();
        end
        else if (is_operator(c))
        begin
            if (c == sclc_pkg::CHAR_PIPE)      op = sclc_pkg::EV_PIPE;
            else if (c == sclc_pkg::CHAR_LESS) op = sclc_pkg::EV_RIN;
            else                               op = sclc_pkg::EV_ROUT;
            if (line_in_word)
                close_word();
            if (line_tokens < TOKEN_CAP)
            begin
                emit(op, 8'h00, sclc_pkg::V_PENDING);
                syntax_feed(op);
                line_tokens++;
            end
        end
        else
        begin
            if (!line_in_word && (line_tokens < TOKEN_CAP))
            begin
                line_in_word  = 1'b1;
                line_word_len = 0;
            end
            if (line_in_word && (line_word_len < WORD_CAP))
            begin
                emit(sclc_pkg::EV_BYTE, c, sclc_pkg::V_PENDING);
                line_word_len++;
            end
        end
        if (step_n > 0)
            step_out[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_events.push_back(step_out[i]);
    endfunction

    task automatic flag_result(input bit had_want, input sclc_pkg::res_beat_t want,
                               input sclc_pkg::res_beat_t got);
        if (mismatch_count < 10)
        begin
            if (had_want)
            begin
                $write("mismatch at %0t: expected ev=%0d byte=%02h idx=%0d verdict=%0d last=%0d",
                       $time, want.event_res, want.out_byte, want.token_index,
                       want.verdict, want.last);
                $display(", got ev=%0d byte=%02h idx=%0d verdict=%0d last=%0d",
                         got.event_res, got.out_byte, got.token_index,
                         got.verdict, got.last);
            end
            else
            begin
                $write("mismatch at %0t: unexpected result ", $time);
                $display("ev=%0d byte=%02h idx=%0d verdict=%0d last=%0d",
                         got.event_res, got.out_byte, got.token_index,
                         got.verdict, got.last);
            end
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_events.size() == 0)
                flag_result(1'b0, '0, res);
            else
            begin
                want_beat = expected_events.pop_front();
                if ((res.event_res !== want_beat.event_res) ||
                    (res.out_byte !== want_beat.out_byte) ||
                    (res.token_index !== want_beat.token_index) ||
                    (res.verdict !== want_beat.verdict) ||
                    (res.last !== want_beat.last))
                    flag_result(1'b1, want_beat, res);
            end
        end
    end

    task automatic send_beat(input logic kind, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        req.req_type  <= kind;
        req.char_byte <= data;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        lex_predict(kind, data);
        beats_taken++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_beat(sclc_pkg::REQ_BYTE, c);
    endtask

    task automatic send_eol();
        send_beat(sclc_pkg::REQ_EOL, 8'($urandom_range(255)));
    endtask

    // sender holds off until the last result beat is back
    task automatic drain_results();
        req_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_blank(c) || is_operator(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(1) == 0)
            return sclc_pkg::CHAR_SPACE;
        return 8'($urandom_range(sclc_pkg::CHAR_CR, sclc_pkg::CHAR_TAB));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(2))
            0:       return sclc_pkg::CHAR_PIPE;
            1:       return sclc_pkg::CHAR_LESS;
            default: return sclc_pkg::CHAR_MORE;
        endcase
    endfunction

    function automatic int pick_word_length();
        if ($urandom_range(99) < 5)
            return $urandom_range(60, 45);
        return $urandom_range(6, 1);
    endfunction

    task automatic send_word(input int len);
        repeat (len) send_byte(pick_word_byte());
    endtask

    task automatic send_blanks(input int lo);
        repeat ($urandom_range(2, lo)) send_byte(pick_blank());
    endtask

    task automatic send_operator(input logic [7:0] op);
        send_blanks(0);
        send_byte(op);
        send_blanks(0);
    endtask

    task automatic send_command_line();
        int segs;
        int roll;
        if ($urandom_range(99) < 25)
        begin
            // noise line
            repeat ($urandom_range(12, 0))
            begin
                roll = $urandom_range(99);
                if (roll < 40)      send_byte(pick_word_byte());
                else if (roll < 60) send_byte(pick_blank());
                else if (roll < 85) send_byte(pick_operator());
                else                send_byte(8'($urandom_range(255)));
            end
        end
        else
        begin
            send_blanks(0);
            segs = $urandom_range(3, 1);
            for (int s = 0; s < segs; s++)
            begin
                if (s > 0)
                    send_operator(sclc_pkg::CHAR_PIPE);
                send_word(pick_word_length());
                repeat ($urandom_range(3, 0))
                begin
                    send_blanks(1);
                    send_word(pick_word_length());
                end
                if ($urandom_range(99) < 30)
                begin
                    send_operator(($urandom_range(1) == 0) ? sclc_pkg::CHAR_LESS
                                                           : sclc_pkg::CHAR_MORE);
                    send_word(pick_word_length());
                end
            end
            // broken tail: dangling operator
            if ($urandom_range(99) < 12)
                send_operator(pick_operator());
            send_blanks(0);
        end
        send_eol();
    endtask

    task automatic test_directed();
        send_beat(sclc_pkg::REQ_EOL, 8'hFF);
        send_byte(sclc_pkg::CHAR_PIPE);
        send_beat(sclc_pkg::REQ_EOL, sclc_pkg::CHAR_PIPE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sclc_pkg::CHAR_LESS);
        send_beat(sclc_pkg::REQ_EOL, 8'h00);
        send_byte("a");
        send_byte(sclc_pkg::CHAR_PIPE);
        send_beat(sclc_pkg::REQ_EOL, 8'h41);
        send_byte("b");
        send_byte(sclc_pkg::CHAR_TAB);
        send_byte(8'h0A);
        send_byte(sclc_pkg::CHAR_MORE);
        send_byte(sclc_pkg::CHAR_SPACE);
        send_byte("c");
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(8'h80);
        send_byte(sclc_pkg::CHAR_CR);
        send_beat(sclc_pkg::REQ_EOL, 8'h20);
        send_byte("x");
        send_byte(sclc_pkg::CHAR_MORE);
        send_byte(sclc_pkg::CHAR_MORE);
        send_beat(sclc_pkg::REQ_EOL, 8'h7F);
    endtask

    task automatic test_long_words();
        send_word(WORD_CAP);
        send_eol();
        send_word(WORD_CAP + 7);
        send_byte(sclc_pkg::CHAR_LESS);
        send_word(WORD_CAP + 1);
        send_eol();
    endtask

    task automatic test_token_limit();
        for (int t = 0; t < 130; t++)
        begin
            if ($urandom_range(99) < 40)
                send_byte(pick_operator());
            else
            begin
                send_word($urandom_range(2, 1));
                if ($urandom_range(1) == 0)
                    send_blanks(1);
            end
        end
        send_word(3);
        send_eol();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = beats_taken + 60;
        while (beats_taken < stop_at)
            send_command_line();
        drain_results();
    endtask

    initial
    begin
        clear_line();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        drain_results();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        test_long_words();
        drain_results();
        test_token_limit();
        drain_results();

        test_random_traffic(0, 0);
        test_random_traffic(85, 0);
        test_random_traffic(0, 85);
        test_random_traffic(12, 12);

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
